[sv/mtep_pkg.sv]
`timescale 1ns / 1ps

package mtep_pkg;

    // parser phase within one track event
    typedef enum logic [2:0] {
        P_DELTA  = 3'd0,
        P_STATUS = 3'd1,
        P_CH1    = 3'd2,
        P_CH2    = 3'd3,
        P_MTYPE  = 3'd4,
        P_MLEN   = 3'd5,
        P_SLEN   = 3'd6,
        P_PAY    = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        K_CHANNEL = 3'd0,
        K_META    = 3'd1,
        K_SYSEX   = 3'd2,
        K_PAYLOAD = 3'd3,
        K_ERROR   = 3'd4
    } t_kind;

    localparam logic [7:0] ST_META     = 8'hFF;
    localparam logic [7:0] ST_SYSEX    = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;
    localparam logic [7:0] META_EOT    = 8'h2F;
    localparam logic [3:0] HI_PROGRAM  = 4'hC;
    localparam logic [3:0] HI_PRESSURE = 4'hD;
    localparam logic [7:0] ST_SYSTEM   = 8'hF0;

    localparam int unsigned VLQ_W   = 28;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned TAG_W   = 16;
    localparam logic [2:0]  VLQ_MAX = 3'd4;

    typedef struct packed {
        logic                 sysex_more;
        logic                 end_of_track;
        logic                 last;
        logic [TAG_W-1:0]     track_tag;
        logic [TIME_W-1:0]    abs_time;
        logic [7:0]           payload;
        logic [VLQ_W-1:0]     data_len;
        logic [7:0]           second_param;
        logic [7:0]           first_param;
        logic [3:0]           channel;
        logic [7:0]           status_code;
        t_kind                kind;
    } t_result;

    function automatic t_phase body_phase(input logic [7:0] st);
        t_phase ph;
        if (st == ST_META) begin
            ph = P_MTYPE;
        end else if (st >= ST_SYSTEM) begin
            ph = P_SLEN;
        end else begin
            ph = P_CH1;
        end
        return ph;
    endfunction

endpackage

[sv/mtep_core.sv]
`timescale 1ns / 1ps

module mtep_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic [7:0]                i_byte,
    input  logic                      i_start,
    input  logic                      i_end,
    input  logic [mtep_pkg::TAG_W-1:0] i_track_tag,
    output logic                      o_res_valid,
    output mtep_pkg::t_result         o_res
);

    mtep_pkg::t_phase                  r_phase, n_phase;
    logic [mtep_pkg::VLQ_W-1:0]        r_vlq, n_vlq;
    logic [2:0]                        r_cnt, n_cnt;
    logic [mtep_pkg::TIME_W-1:0]       r_time, n_time;
    logic [7:0]                        r_prev, n_prev;
    logic                              r_prev_ok, n_prev_ok;
    logic [7:0]                        r_cur, n_cur;
    logic [7:0]                        r_held, n_held;
    logic [mtep_pkg::VLQ_W-1:0]        r_left, n_left;
    logic                              r_done, n_done;

    always_comb begin
        mtep_pkg::t_phase            c_phase, b_phase;
        logic [mtep_pkg::VLQ_W-1:0]  c_vlq, c_left, v_vlq, left_m;
        logic [2:0]                  c_cnt, v_cnt;
        logic [mtep_pkg::TIME_W-1:0] c_time;
        logic [7:0]                  c_prev, c_cur, c_held, b_cur, b_held;
        logic                        c_prev_ok, c_done, v_full, run_body, do_fail;
        logic                        is_meta, eot, lastb, stop;

        // a track start clears the per-track state before the byte is used
        c_phase   = i_start ? mtep_pkg::P_DELTA : r_phase;
        c_vlq     = i_start ? '0 : r_vlq;
        c_cnt     = i_start ? '0 : r_cnt;
        c_time    = i_start ? '0 : r_time;
        c_prev    = i_start ? '0 : r_prev;
        c_prev_ok = i_start ? 1'b0 : r_prev_ok;
        c_cur     = i_start ? '0 : r_cur;
        c_held    = i_start ? '0 : r_held;
        c_left    = i_start ? '0 : r_left;
        c_done    = i_start ? 1'b0 : r_done;

        n_phase   = c_phase;
        n_vlq     = c_vlq;
        n_cnt     = c_cnt;
        n_time    = c_time;
        n_prev    = c_prev;
        n_prev_ok = c_prev_ok;
        n_cur     = c_cur;
        n_held    = c_held;
        n_left    = c_left;
        n_done    = c_done;

        v_vlq   = {c_vlq[mtep_pkg::VLQ_W-8:0], i_byte[6:0]};
        v_cnt   = c_cnt + 3'd1;
        v_full  = !i_byte[7] || (v_cnt >= mtep_pkg::VLQ_MAX);
        left_m  = c_left - {{(mtep_pkg::VLQ_W-1){1'b0}}, 1'b1};
        lastb   = (left_m == '0);
        b_cur   = c_cur;
        b_held  = c_held;
        b_phase = c_phase;
        run_body = 1'b0;
        do_fail  = 1'b0;
        is_meta  = 1'b0;
        eot      = 1'b0;
        stop     = 1'b0;

        o_res_valid = 1'b0;
        o_res = '0;

        if (!c_done) begin
            case (c_phase)
                mtep_pkg::P_DELTA: begin
                    n_vlq = v_vlq;
                    n_cnt = v_cnt;
                    if (v_full) begin
                        n_time  = c_time + {{(mtep_pkg::TIME_W-mtep_pkg::VLQ_W){1'b0}}, v_vlq};
                        n_vlq   = '0;
                        n_cnt   = '0;
                        n_phase = mtep_pkg::P_STATUS;
                    end
                    do_fail = i_end;
                end
                mtep_pkg::P_STATUS: begin
                    if (i_byte[7]) begin
                        n_cur     = i_byte;
                        n_prev    = i_byte;
                        n_prev_ok = 1'b1;
                        n_held    = '0;
                        n_phase   = mtep_pkg::body_phase(i_byte);
                        do_fail   = i_end;
                    end else if (!c_prev_ok) begin
                        do_fail = 1'b1;
                    end else begin
                        // running status: the byte is the first body byte
                        n_cur    = c_prev;
                        n_held   = '0;
                        b_cur    = c_prev;
                        b_held   = '0;
                        b_phase  = mtep_pkg::body_phase(c_prev);
                        n_phase  = b_phase;
                        run_body = 1'b1;
                    end
                end
                default: begin
                    run_body = 1'b1;
                end
            endcase

            if (run_body) begin
                case (b_phase)
                    mtep_pkg::P_CH1: begin
                        if (b_cur[7:4] == mtep_pkg::HI_PROGRAM ||
                            b_cur[7:4] == mtep_pkg::HI_PRESSURE) begin
                            o_res_valid        = 1'b1;
                            o_res.kind         = mtep_pkg::K_CHANNEL;
                            o_res.status_code  = b_cur;
                            o_res.channel      = b_cur[3:0];
                            o_res.first_param  = i_byte;
                            o_res.last         = 1'b1;
                            n_phase = mtep_pkg::P_DELTA;
                            n_vlq   = '0;
                            n_cnt   = '0;
                            n_left  = '0;
                            stop    = i_end;
                        end else if (i_end) begin
                            do_fail = 1'b1;
                        end else begin
                            n_held  = i_byte;
                            n_phase = mtep_pkg::P_CH2;
                        end
                    end
                    mtep_pkg::P_CH2: begin
                        o_res_valid        = 1'b1;
                        o_res.kind         = mtep_pkg::K_CHANNEL;
                        o_res.status_code  = b_cur;
                        o_res.channel      = b_cur[3:0];
                        o_res.first_param  = b_held;
                        o_res.second_param = i_byte;
                        o_res.last         = 1'b1;
                        n_phase = mtep_pkg::P_DELTA;
                        n_vlq   = '0;
                        n_cnt   = '0;
                        n_left  = '0;
                        stop    = i_end;
                    end
                    mtep_pkg::P_MTYPE: begin
                        if (i_end) begin
                            do_fail = 1'b1;
                        end else begin
                            n_held  = i_byte;
                            n_vlq   = '0;
                            n_cnt   = '0;
                            n_phase = mtep_pkg::P_MLEN;
                        end
                    end
                    mtep_pkg::P_MLEN, mtep_pkg::P_SLEN: begin
                        n_vlq = v_vlq;
                        n_cnt = v_cnt;
                        if (!v_full) begin
                            do_fail = i_end;
                        end else if (v_vlq != '0 && i_end) begin
                            do_fail = 1'b1;
                        end else begin
                            is_meta = (b_phase == mtep_pkg::P_MLEN);
                            eot     = is_meta && (b_held == mtep_pkg::META_EOT);
                            o_res_valid        = 1'b1;
                            o_res.kind         = is_meta ? mtep_pkg::K_META
                                                         : mtep_pkg::K_SYSEX;
                            o_res.status_code  = b_cur;
                            o_res.first_param  = is_meta ? b_held : 8'h00;
                            o_res.data_len     = v_vlq;
                            o_res.last         = (v_vlq == '0);
                            o_res.end_of_track = eot;
                            if (v_vlq == '0) begin
                                n_phase = mtep_pkg::P_DELTA;
                                n_vlq   = '0;
                                n_cnt   = '0;
                                n_left  = '0;
                                stop    = i_end || eot;
                            end else begin
                                n_left  = v_vlq;
                                n_phase = mtep_pkg::P_PAY;
                            end
                        end
                    end
                    mtep_pkg::P_PAY: begin
                        n_left = left_m;
                        if (!lastb && i_end) begin
                            do_fail = 1'b1;
                        end else begin
                            eot = (b_cur == mtep_pkg::ST_META) &&
                                  (b_held == mtep_pkg::META_EOT);
                            o_res_valid        = 1'b1;
                            o_res.kind         = mtep_pkg::K_PAYLOAD;
                            o_res.status_code  = b_cur;
                            o_res.data_len     = c_vlq;
                            o_res.payload      = i_byte;
                            o_res.last         = lastb;
                            o_res.end_of_track = eot;
                            o_res.sysex_more   = lastb && (b_cur == mtep_pkg::ST_SYSEX) &&
                                                 (i_byte != mtep_pkg::SYSEX_END);
                            if (lastb) begin
                                n_phase = mtep_pkg::P_DELTA;
                                n_vlq   = '0;
                                n_cnt   = '0;
                                n_left  = '0;
                                stop    = i_end || eot;
                            end
                        end
                    end
                    default: begin
                        do_fail = 1'b1;
                    end
                endcase
            end

            if (stop) begin
                n_done = 1'b1;
            end

            // error result overrides whatever the byte would have given
            if (do_fail) begin
                n_done  = 1'b1;
                n_phase = mtep_pkg::P_DELTA;
                n_vlq   = '0;
                n_cnt   = '0;
                o_res_valid = 1'b1;
                o_res       = '0;
                o_res.kind  = mtep_pkg::K_ERROR;
                o_res.last  = 1'b1;
            end
        end

        o_res.abs_time  = n_time;
        o_res.track_tag = i_track_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= mtep_pkg::P_DELTA;
            r_vlq     <= '0;
            r_cnt     <= '0;
            r_time    <= '0;
            r_prev    <= '0;
            r_prev_ok <= 1'b0;
            r_cur     <= '0;
            r_held    <= '0;
            r_left    <= '0;
            r_done    <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_vlq     <= n_vlq;
            r_cnt     <= n_cnt;
            r_time    <= n_time;
            r_prev    <= n_prev;
            r_prev_ok <= n_prev_ok;
            r_cur     <= n_cur;
            r_held    <= n_held;
            r_left    <= n_left;
            r_done    <= n_done;
        end
    end

endmodule

[sv/midi_track_event_parser_top.sv]
// Track event parser for standard MIDI file data. One track byte enters per
// request on the slave stream and each byte gives at most one result on the
// master stream, so the block sustains one byte per clock cycle while the
// master side accepts; a byte's result is loaded into the result register as
// the byte leaves the input register (the parse logic sits between the two),
// and a stalled master side holds the input register and then the slave side.
// The parse state (delta-time count, running status, meta/sysex length and
// payload countdown) is updated once per byte in a single pass. Register
// track_index answers every address of the APB port and is stamped on every
// result; write it only while idle.
`timescale 1ns / 1ps

module midi_track_event_parser_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tlast,   // track_end
    input  logic [0:0]   s_axis_tuser,   // [0] track_start
    // master stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] status_code, [11:8] channel, [19:12] first_param,
    // [27:20] second_param, [55:28] data_len, [63:56] payload,
    // [95:64] abs_time, [111:96] track_tag
    output logic [111:0] m_axis_tdata,
    output logic         m_axis_tlast,   // last
    output logic [4:0]   m_axis_tuser,   // [2:0] kind, [3] end_of_track, [4] sysex_more
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [mtep_pkg::TAG_W-1:0] r_track_index;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;
    logic       r_in_end;

    logic              r_out_valid;
    mtep_pkg::t_result r_out;

    logic              out_free;
    logic              step;
    logic              res_valid;
    mtep_pkg::t_result res;

    // only one register, so every word address maps onto it
    assign pready = 1'b1;
    assign prdata = {{(32-mtep_pkg::TAG_W){1'b0}}, r_track_index};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_index <= '0;
        end else if (psel && penable && pwrite && pready && (paddr[1:0] == 2'd0 ||
                     paddr[1:0] != 2'd0)) begin
            r_track_index <= pwdata[mtep_pkg::TAG_W-1:0];
        end
    end

    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser[0];
            r_in_end   <= s_axis_tlast;
        end
    end

    mtep_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_start     (r_in_start),
        .i_end       (r_in_end),
        .i_track_tag (r_track_index),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tuser  = {r_out.sysex_more, r_out.end_of_track, r_out.kind};
    assign m_axis_tdata  = {r_out.track_tag, r_out.abs_time, r_out.payload,
                            r_out.data_len, r_out.second_param, r_out.first_param,
                            r_out.channel, r_out.status_code};

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] TRACK_INDEX_ADDR = 2'd0;

    typedef struct packed {
        logic [7:0] b;
        logic       st;
        logic       en;
        logic       fixed;
    } t_row;

    // error result at tick zero with the directed track tag
    localparam mtep_pkg::t_result ERR_AT_ZERO = '{
        sysex_more: 1'b0, end_of_track: 1'b0, last: 1'b1, track_tag: 16'hFFFF,
        abs_time: 32'd0, payload: 8'd0, data_len: 28'd0, second_param: 8'd0,
        first_param: 8'd0, channel: 4'd0, status_code: 8'd0, kind: mtep_pkg::K_ERROR};

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'd0;    // [7:0] data_byte
    logic         s_axis_tlast = 1'b0;
    logic [0:0]   s_axis_tuser = 1'b0;    // [0] track_start
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [7:0] status_code, [11:8] channel, [19:12] first_param, [27:20] second_param,
    // [55:28] data_len, [63:56] payload, [95:64] abs_time, [111:96] track_tag
    logic [111:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic [4:0]   m_axis_tuser;           // [2:0] kind, [3] end_of_track, [4] sysex_more
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [1:0]   paddr = 2'd0;
    logic [31:0]  pwdata = 32'd0;
    logic [31:0]  prdata;
    logic         pready;

    midi_track_event_parser_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // parser shadow state
    mtep_pkg::t_phase ph;
    logic [27:0] cnt_val;
    logic [2:0]  cnt_bytes;
    logic [31:0] tick_total;
    logic [7:0]  last_status;
    bit          last_status_ok;
    logic [7:0]  event_status;
    logic [7:0]  held;
    logic [27:0] remaining;
    bit          track_over;
    logic [15:0] tag_reg;

    mtep_pkg::t_result pending_events [$];
    t_row        track_q [$];
    logic [7:0]  gen_prev;
    bit          gen_prev_ok;
    int unsigned mismatches = 0;
    int unsigned useful_items = 0;
    bit          no_idle = 1'b0;
    bit          squeeze_req = 1'b0;
    bit          squeeze_done = 1'b0;

    t_row directed_rows [26] = '{
        '{8'h00, 1'b1, 1'b0, 1'b0},
        '{8'h40, 1'b0, 1'b0, 1'b1},   // running status with nothing before it
        '{8'hFF, 1'b1, 1'b0, 1'b0},   // four-byte delta, largest count
        '{8'hFF, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0},
        '{8'h90, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0},
        '{8'h7F, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0},
        '{8'hC5, 1'b0, 1'b0, 1'b0},   // program change, one data byte
        '{8'h7F, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0},
        '{8'hF0, 1'b0, 1'b0, 1'b0},
        '{8'h01, 1'b0, 1'b0, 1'b0},
        '{8'h10, 1'b0, 1'b0, 1'b0},   // sysex continues
        '{8'h00, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0},   // running status on sysex, empty body
        '{8'h00, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0},
        '{8'h2F, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0},   // end of track
        '{8'h90, 1'b0, 1'b0, 1'b0},   // ignored after end of track
        '{8'h00, 1'b1, 1'b0, 1'b0},
        '{8'h90, 1'b0, 1'b0, 1'b0},
        '{8'h3C, 1'b0, 1'b1, 1'b1}    // track cut between channel bytes
    };

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb: FAIL");
        $finish;
    end

    function automatic mtep_pkg::t_result make_res(input mtep_pkg::t_kind kind,
                                                   input logic [7:0] st,
                                                   input logic [3:0] ch, input logic [7:0] p1,
                                                   input logic [7:0] p2, input logic [27:0] len,
                                                   input logic [7:0] pay, input logic lst,
                                                   input logic eot, input logic more);
        mtep_pkg::t_result r;
        r.kind         = kind;
        r.status_code  = st;
        r.channel      = ch;
        r.first_param  = p1;
        r.second_param = p2;
        r.data_len     = len;
        r.payload      = pay;
        r.abs_time     = tick_total;
        r.track_tag    = tag_reg;
        r.last         = lst;
        r.end_of_track = eot;
        r.sysex_more   = more;
        return r;
    endfunction

    function automatic bit count_step(input logic [7:0] b);
        cnt_val   = {cnt_val[20:0], b[6:0]};
        cnt_bytes = cnt_bytes + 3'd1;
        return !b[7] || cnt_bytes >= mtep_pkg::VLQ_MAX;
    endfunction

    function automatic void close_event(input bit stop);
        ph        = mtep_pkg::P_DELTA;
        cnt_val   = '0;
        cnt_bytes = '0;
        remaining = '0;
        if (stop) track_over = 1'b1;
    endfunction

    function automatic mtep_pkg::t_result abort_track();
        track_over = 1'b1;
        ph         = mtep_pkg::P_DELTA;
        cnt_val    = '0;
        cnt_bytes  = '0;
        return make_res(mtep_pkg::K_ERROR, 8'd0, 4'd0, 8'd0, 8'd0, 28'd0, 8'd0,
                        1'b1, 1'b0, 1'b0);
    endfunction

    function automatic mtep_pkg::t_phase body_of(input logic [7:0] st);
        if (st == mtep_pkg::ST_META) return mtep_pkg::P_MTYPE;
        if (st >= mtep_pkg::ST_SYSTEM) return mtep_pkg::P_SLEN;
        return mtep_pkg::P_CH1;
    endfunction

    task automatic parse_track_byte(input logic [7:0] b, input logic st, input logic en,
                                    output bit got, output mtep_pkg::t_result r);
        logic [27:0] len;
        bit          lastb;
        bit          eot;
        bit          is_meta;
        got = 1'b0;
        r   = '0;
        if (st) begin
            tick_total     = '0;
            last_status    = '0;
            last_status_ok = 1'b0;
            track_over     = 1'b0;
            event_status   = '0;
            held           = '0;
            close_event(1'b0);
        end
        if (track_over) return;

        if (ph == mtep_pkg::P_DELTA) begin
            if (count_step(b)) begin
                tick_total = tick_total + 32'(cnt_val);
                cnt_val    = '0;
                cnt_bytes  = '0;
                ph         = mtep_pkg::P_STATUS;
            end
            if (en) begin
                r   = abort_track();
                got = 1'b1;
            end
            return;
        end

        if (ph == mtep_pkg::P_STATUS) begin
            if (b[7]) begin
                event_status   = b;
                last_status    = b;
                last_status_ok = 1'b1;
                held           = '0;
                ph             = body_of(b);
                if (en) begin
                    r   = abort_track();
                    got = 1'b1;
                end
                return;
            end
            if (!last_status_ok) begin
                r   = abort_track();
                got = 1'b1;
                return;
            end
            // running status: this byte starts the body
            event_status = last_status;
            held         = '0;
            ph           = body_of(event_status);
        end

        case (ph)
            mtep_pkg::P_CH1: begin
                if (event_status[7:4] == mtep_pkg::HI_PROGRAM ||
                    event_status[7:4] == mtep_pkg::HI_PRESSURE) begin
                    r = make_res(mtep_pkg::K_CHANNEL, event_status, event_status[3:0], b,
                                 8'd0, 28'd0, 8'd0, 1'b1, 1'b0, 1'b0);
                    got = 1'b1;
                    close_event(en);
                end else if (en) begin
                    r   = abort_track();
                    got = 1'b1;
                end else begin
                    held = b;
                    ph   = mtep_pkg::P_CH2;
                end
            end
            mtep_pkg::P_CH2: begin
                r = make_res(mtep_pkg::K_CHANNEL, event_status, event_status[3:0], held, b,
                             28'd0, 8'd0, 1'b1, 1'b0, 1'b0);
                got = 1'b1;
                close_event(en);
            end
            mtep_pkg::P_MTYPE: begin
                if (en) begin
                    r   = abort_track();
                    got = 1'b1;
                end else begin
                    held      = b;
                    cnt_val   = '0;
                    cnt_bytes = '0;
                    ph        = mtep_pkg::P_MLEN;
                end
            end
            mtep_pkg::P_MLEN, mtep_pkg::P_SLEN: begin
                if (!count_step(b)) begin
                    if (en) begin
                        r   = abort_track();
                        got = 1'b1;
                    end
                end else begin
                    len     = cnt_val;
                    is_meta = (ph == mtep_pkg::P_MLEN);
                    eot     = is_meta && held == mtep_pkg::META_EOT;
                    got     = 1'b1;
                    if (len != 0 && en) begin
                        r = abort_track();
                    end else begin
                        r = make_res(is_meta ? mtep_pkg::K_META : mtep_pkg::K_SYSEX,
                                     event_status, 4'd0, is_meta ? held : 8'd0, 8'd0, len,
                                     8'd0, len == 0, eot, 1'b0);
                        if (len == 0) begin
                            close_event(en || eot);
                        end else begin
                            remaining = len;
                            ph        = mtep_pkg::P_PAY;
                        end
                    end
                end
            end
            default: begin
                remaining = remaining - 28'd1;
                lastb     = (remaining == 0);
                got       = 1'b1;
                if (!lastb && en) begin
                    r = abort_track();
                end else begin
                    eot = event_status == mtep_pkg::ST_META && held == mtep_pkg::META_EOT;
                    r = make_res(mtep_pkg::K_PAYLOAD, event_status, 4'd0, 8'd0, 8'd0, cnt_val,
                                 b, lastb, eot,
                                 lastb && event_status == mtep_pkg::ST_SYSEX &&
                                 b != mtep_pkg::SYSEX_END);
                    if (lastb) close_event(en || eot);
                end
            end
        endcase
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : watch_results
        mtep_pkg::t_result seen;
        mtep_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.status_code  = m_axis_tdata[7:0];
            seen.channel      = m_axis_tdata[11:8];
            seen.first_param  = m_axis_tdata[19:12];
            seen.second_param = m_axis_tdata[27:20];
            seen.data_len     = m_axis_tdata[55:28];
            seen.payload      = m_axis_tdata[63:56];
            seen.abs_time     = m_axis_tdata[95:64];
            seen.track_tag    = m_axis_tdata[111:96];
            seen.last         = m_axis_tlast;
            seen.kind         = mtep_pkg::t_kind'(m_axis_tuser[2:0]);
            seen.end_of_track = m_axis_tuser[3];
            seen.sysex_more   = m_axis_tuser[4];
            if (pending_events.size() == 0) begin
                $display("%0t unexpected result: expected none, got %h", $time, seen);
                mismatches++;
            end else begin
                want = pending_events.pop_front();
                check_field("kind", 32'(want.kind), 32'(seen.kind));
                check_field("status_code", 32'(want.status_code), 32'(seen.status_code));
                check_field("channel", 32'(want.channel), 32'(seen.channel));
                check_field("first_param", 32'(want.first_param), 32'(seen.first_param));
                check_field("second_param", 32'(want.second_param), 32'(seen.second_param));
                check_field("data_len", 32'(want.data_len), 32'(seen.data_len));
                check_field("payload", 32'(want.payload), 32'(seen.payload));
                check_field("abs_time", want.abs_time, seen.abs_time);
                check_field("track_tag", 32'(want.track_tag), 32'(seen.track_tag));
                check_field("last", 32'(want.last), 32'(seen.last));
                check_field("end_of_track", 32'(want.end_of_track), 32'(seen.end_of_track));
                check_field("sysex_more", 32'(want.sysex_more), 32'(seen.sysex_more));
            end
        end
    end

    // result side: random stalls, one long hold-off while the sender keeps pushing
    initial begin
        forever begin
            @(posedge i_clk);
            if (squeeze_req && !squeeze_done) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                squeeze_done = 1'b1;
            end else if (no_idle) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= 38);
            end
        end
    end

    task automatic program_track_index(input logic [15:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TRACK_INDEX_ADDR;
        pwdata  <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata[15:0] !== value) begin
            $display("%0t mismatch track_index readback: expected %0h, got %0h",
                     $time, value, prdata[15:0]);
            mismatches++;
        end
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        tag_reg = value;
    endtask

    task automatic send_byte(input t_row row);
        bit                got;
        mtep_pkg::t_result res;
        if (!(no_idle || (squeeze_req && !squeeze_done))) begin
            while ($urandom_range(0, 99) < 38) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= row.b;
        s_axis_tlast  <= row.en;
        s_axis_tuser  <= row.st;
        do @(posedge i_clk); while (!s_axis_tready);
        if (row.st || !track_over) useful_items++;
        parse_track_byte(row.b, row.st, row.en, got, res);
        if (got) pending_events.push_back(row.fixed ? ERR_AT_ZERO : res);
    endtask

    task automatic push(input logic [7:0] b);
        track_q.push_back('{b: b, st: 1'b0, en: 1'b0, fixed: 1'b0});
    endtask

    // variable-length count, sometimes padded or with the fourth byte flagged
    task automatic push_count(input logic [27:0] v, input bit may_pad);
        int         n;
        int         i;
        bit         overlong;
        logic [7:0] cb;
        n = 1;
        if (v >= 28'h80) n = 2;
        if (v >= 28'h4000) n = 3;
        if (v >= 28'h200000) n = 4;
        overlong = 1'b0;
        if (may_pad && $urandom_range(0, 99) < 10) n = int'($urandom_range(n, 4));
        if (may_pad && n == 4 && $urandom_range(0, 9) < 3) overlong = 1'b1;
        for (i = n - 1; i >= 0; i--) begin
            cb = {(i > 0) || overlong, 7'(v >> (7 * i))};
            push(cb);
        end
    endtask

    task automatic gen_event(input bit max_delta);
        logic [7:0] s;
        logic [7:0] mtype;
        int         len;
        int         k;
        int         pick;
        bit         running;
        if (max_delta) begin
            push_count(28'hFFFFFFF, 1'b0);
        end else begin
            pick = $urandom_range(0, 9);
            if (pick < 7) push_count(28'($urandom_range(0, 127)), 1'b1);
            else if (pick < 9) push_count(28'($urandom_range(0, 16383)), 1'b1);
            else push_count(28'($urandom), 1'b1);
        end
        running = gen_prev_ok && $urandom_range(0, 99) < 25;
        if (running) begin
            s = gen_prev;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 50) s = 8'($urandom_range(8'h80, 8'hEF));
            else if (pick < 70) s = mtep_pkg::ST_META;
            else if (pick < 85) s = mtep_pkg::ST_SYSEX;
            else s = 8'($urandom_range(8'hF1, 8'hFE));
            push(s);
            gen_prev    = s;
            gen_prev_ok = 1'b1;
        end
        if (s == mtep_pkg::ST_META) begin
            mtype = 8'($urandom_range(0, 8'h7F));
            if (mtype == mtep_pkg::META_EOT) mtype = 8'h51;
            push(mtype);
            len = $urandom_range(0, 6);
            push_count(28'(len), 1'b1);
            repeat (len) push(8'($urandom));
        end else if (s >= mtep_pkg::ST_SYSEX) begin
            len = $urandom_range(0, 6);
            // under running status the count byte must look like data
            push_count(28'(len), !running);
            for (k = 0; k < len; k++) begin
                if (k == len - 1 && s == mtep_pkg::ST_SYSEX && $urandom_range(0, 1))
                    push(mtep_pkg::SYSEX_END);
                else push(8'($urandom));
            end
        end else begin
            push(8'($urandom_range(0, 8'h7F)));
            if (s[7:4] != mtep_pkg::HI_PROGRAM && s[7:4] != mtep_pkg::HI_PRESSURE)
                push(8'($urandom_range(0, 8'h7F)));
        end
    endtask

    task automatic play_track();
        int n;
        int k;
        int pick;
        bit max_delta;
        track_q.delete();
        gen_prev_ok = ($urandom_range(0, 19) == 0);
        gen_prev    = 8'($urandom_range(8'h80, 8'hEF));
        if ($urandom_range(0, 99) < 12) begin
            n = $urandom_range(3, 20);
            repeat (n) begin
                track_q.push_back('{b: 8'($urandom), st: $urandom_range(0, 99) < 8,
                                    en: $urandom_range(0, 99) < 8, fixed: 1'b0});
            end
        end else begin
            max_delta = $urandom_range(0, 99) < 5;
            n = max_delta ? 18 : int'($urandom_range(1, 8));
            repeat (n) gen_event(max_delta);
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                push_count(28'($urandom_range(0, 127)), 1'b1);
                push(mtep_pkg::ST_META);
                push(mtep_pkg::META_EOT);
                push(8'h00);
            end else if (pick < 60) begin
                track_q[track_q.size() - 1].en = 1'b1;
            end else if (pick < 75) begin
                k = int'($urandom_range(0, track_q.size() - 1));
                while (track_q.size() > k + 1) void'(track_q.pop_back());
                track_q[k].en = 1'b1;
            end else if (pick < 82) begin
                // huge meta length, cut off after two payload bytes
                push(8'h00);
                push(mtep_pkg::ST_META);
                push(8'h01);
                push_count(28'hFFFFFFF, 1'b0);
                push(8'($urandom));
                push(8'($urandom));
                track_q[track_q.size() - 1].en = 1'b1;
            end
        end
        track_q[0].st = 1'b1;
        for (k = 0; k < track_q.size(); k++) send_byte(track_q[k]);
    endtask

    task automatic drain();
        while (pending_events.size() != 0) @(posedge i_clk);
        // bytes that give no result may still be in flight
        repeat (10) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int          round;
        int          i;
        logic [15:0] tag;
        ph             = mtep_pkg::P_DELTA;
        cnt_val        = '0;
        cnt_bytes      = '0;
        tick_total     = '0;
        last_status    = '0;
        last_status_ok = 1'b0;
        event_status   = '0;
        held           = '0;
        remaining      = '0;
        track_over     = 1'b0;
        tag_reg        = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        program_track_index(16'hFFFF);
        for (i = 0; i < 26; i++) send_byte(directed_rows[i]);
        s_axis_tvalid <= 1'b0;

        useful_items = 0;
        for (round = 0; round < 5; round++) begin
            drain();
            tag = (round == 0) ? 16'h0000 : (round == 2) ? 16'hFFFF : 16'($urandom);
            program_track_index(tag);
            squeeze_req = (round == 1);
            no_idle     = (round == 3);
            while (useful_items < 320 * (round + 1)) play_track();
            s_axis_tvalid <= 1'b0;
        end
        squeeze_req = 1'b0;
        no_idle     = 1'b0;
        drain();
        if (mismatches == 0 && pending_events.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
